@@ rtl/tmse_pkg.sv @@
// Shared types and constants for the Turing machine step engine.
// Used by the core, the sequencer and the checker; depends on nothing else.
package tmse_pkg;

    // Defaults for the top-level parameters.
    localparam int TAPE_DEPTH_DEF  = 1024;
    localparam int STATE_COUNT_DEF = 64;

    // Fixed field widths.
    localparam int SYM_W  = 8;
    localparam int ST_W   = 6;
    localparam int MOVE_W = 2;
    localparam int CIDX_W = 10;
    localparam int LEN_W  = 11;
    localparam int STAT_W = 2;

    // Request kinds.
    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_TAPE   = 2'd2,
        MODE_STEP   = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_RULE = 2'd1,
        STAT_BEYOND  = 2'd2
    } status_t;

    // Head move codes; the unused code behaves as stay.
    localparam logic [MOVE_W-1:0] MOVE_STAY  = 2'd0;
    localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd1;
    localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd2;

    // One rule table entry.
    typedef struct packed {
        logic              valid;
        logic [SYM_W-1:0]  sym;
        logic [ST_W-1:0]   state;
        logic [MOVE_W-1:0] move;
    } rule_t;

    localparam int RULE_W = $bits(rule_t);

    // Sequencer states.
    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_FINISH,
        FSM_ADD_CHK,
        FSM_STEP_RULE,
        FSM_STEP_APPLY
    } fsm_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic  in_valid;
        mode_t mode;
        logic  head_ok;
        logic  out_free;
    } seq_in_t;

    // Sequencer controls to the datapath.
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic clearing;
        logic lookup;
        logic at_add;
        logic at_apply;
        logic fire;
    } seq_out_t;

endpackage

@@ rtl/turing_machine_step_engine_core.sv @@
// Sequence: add, remove, tape load and out-of-tape steps go from acceptance straight to a
// finishing state; a step that reads the tape passes the rule lookup state first, as the
// tape read, then the rule read, then the write-back run through the registered-read memories.
// A result is registered once the output register is free; only then is a new request taken.
// Reset: state and head go to 0, tape_length to 1024, and a clearing pass over all 256 << clog2
// (STATE_COUNT) rule entries (16384 by default) invalidates the rule table before requests.
module turing_machine_step_engine_core
    import tmse_pkg::*;
#(
    parameter int TAPE_DEPTH  = TAPE_DEPTH_DEF,
    parameter int STATE_COUNT = STATE_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_data,
    // Request channel.
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic [SYM_W-1:0]  read_symbol,
    input  logic [ST_W-1:0]   from_state,
    input  logic [SYM_W-1:0]  write_symbol,
    input  logic [ST_W-1:0]   to_state,
    input  logic [MOVE_W-1:0] head_move,
    input  logic [CIDX_W-1:0] cell_index,
    input  logic [SYM_W-1:0]  cell_value,
    // Result channel.
    output logic              out_valid,
    input  logic              out_ready,
    output logic [STAT_W-1:0] status,
    output logic [ST_W-1:0]   machine_state,
    output logic [LEN_W-1:0]  head_position,
    output logic [SYM_W-1:0]  written_symbol
);

    localparam int SW         = $clog2(STATE_COUNT);
    localparam int RULE_AW    = SYM_W + SW;
    localparam int RULE_DEPTH = 2 ** RULE_AW;
    localparam int TAW        = $clog2(TAPE_DEPTH);

    seq_in_t  seq_in;
    seq_out_t seq_out;
    logic [RULE_AW-1:0] clr_addr;

    // Architectural and request registers.
    logic [LEN_W-1:0]  tape_len_reg;
    logic [ST_W-1:0]   cur_state_reg, cur_state_next;
    logic [LEN_W-1:0]  head_reg, head_next;
    mode_t             req_mode_reg;
    logic [SYM_W-1:0]  req_rsym_reg;
    logic [ST_W-1:0]   req_fst_reg;
    logic [SYM_W-1:0]  req_wsym_reg;
    logic [ST_W-1:0]   req_tst_reg;
    logic [MOVE_W-1:0] req_move_reg;
    logic              req_add_ok_reg;

    // Output register.
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ST_W-1:0]   out_state_reg;
    logic [LEN_W-1:0]  out_head_reg;
    logic [SYM_W-1:0]  out_sym_reg;

    // Memory ports.
    logic               rule_we, rule_re;
    logic [RULE_AW-1:0] rule_waddr, rule_raddr;
    rule_t              rule_wdata, rule_rdata;
    logic [RULE_W-1:0]  rule_rdata_raw;
    logic               tape_we, tape_re;
    logic [TAW-1:0]     tape_waddr, tape_raddr;
    logic [SYM_W-1:0]   tape_wdata, tape_rdata;

    // Decoded request and result.
    mode_t              in_mode;
    logic               fst_ok, tst_ok, cidx_ok, head_ok;
    logic [RULE_AW-1:0] in_key, req_key, look_key;
    logic               add_write, apply_write;
    status_t            res_status;
    logic [SYM_W-1:0]   res_sym;

    assign in_mode = mode_t'(mode);
    assign fst_ok  = (32'(from_state) < STATE_COUNT);
    assign tst_ok  = (32'(to_state) < STATE_COUNT);
    assign cidx_ok = (32'(cell_index) < TAPE_DEPTH);
    assign head_ok = (head_reg < tape_len_reg) && (32'(head_reg) < TAPE_DEPTH);

    assign in_key   = {read_symbol, SW'(from_state)};
    assign req_key  = {req_rsym_reg, SW'(req_fst_reg)};
    assign look_key = {tape_rdata, SW'(cur_state_reg)};

    assign rule_rdata = rule_t'(rule_rdata_raw);

    // Sequencer.
    assign seq_in.in_valid = in_valid;
    assign seq_in.mode     = in_mode;
    assign seq_in.head_ok  = head_ok;
    assign seq_in.out_free = !out_valid_reg || out_ready;

    tmse_ctrl #(
        .RULE_AW (RULE_AW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .seq_in   (seq_in),
        .seq_out  (seq_out),
        .clr_addr (clr_addr)
    );

    assign in_ready  = seq_out.in_ready;
    assign cfg_ready = 1'b1;

    assign add_write   = seq_out.fire && seq_out.at_add && !rule_rdata.valid && req_add_ok_reg;
    assign apply_write = seq_out.fire && seq_out.at_apply && rule_rdata.valid;

    // Rule table port control. Reads and writes of one request fall in separate
    // cycles and requests run one at a time, so no forwarding is needed.
    always_comb
    begin
        rule_we    = 1'b0;
        rule_waddr = req_key;
        rule_wdata = '0;
        if (seq_out.clearing)
        begin
            rule_we    = 1'b1;
            rule_waddr = clr_addr;
        end
        else if (seq_out.accept && in_mode == MODE_REMOVE && fst_ok)
        begin
            rule_we    = 1'b1;
            rule_waddr = in_key;
        end
        else if (add_write)
        begin
            rule_we          = 1'b1;
            rule_wdata.valid = 1'b1;
            rule_wdata.sym   = req_wsym_reg;
            rule_wdata.state = req_tst_reg;
            rule_wdata.move  = req_move_reg;
        end
    end

    assign rule_re    = (seq_out.accept && in_mode == MODE_ADD) || seq_out.lookup;
    assign rule_raddr = seq_out.lookup ? look_key : in_key;

    tmse_ram #(
        .WIDTH (RULE_W),
        .DEPTH (RULE_DEPTH)
    ) u_rule_ram (
        .clk   (clk),
        .we    (rule_we),
        .waddr (rule_waddr),
        .wdata (rule_wdata),
        .re    (rule_re),
        .raddr (rule_raddr),
        .rdata (rule_rdata_raw)
    );

    // Tape port control: loads at accept, step write-back when a rule applies.
    always_comb
    begin
        tape_we    = 1'b0;
        tape_waddr = TAW'(head_reg);
        tape_wdata = rule_rdata.sym;
        if (seq_out.accept && in_mode == MODE_TAPE && cidx_ok)
        begin
            tape_we    = 1'b1;
            tape_waddr = TAW'(cell_index);
            tape_wdata = cell_value;
        end
        else if (apply_write)
        begin
            tape_we = 1'b1;
        end
    end

    assign tape_re    = seq_out.accept && in_mode == MODE_STEP;
    assign tape_raddr = TAW'(head_reg);

    tmse_ram #(
        .WIDTH (SYM_W),
        .DEPTH (TAPE_DEPTH)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .re    (tape_re),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    // Result of the finishing request and the new state and head.
    always_comb
    begin
        res_status     = STAT_OK;
        res_sym        = '0;
        cur_state_next = cur_state_reg;
        head_next      = head_reg;
        if (seq_out.at_apply)
        begin
            if (!rule_rdata.valid)
            begin
                res_status = STAT_NO_RULE;
            end
            else
            begin
                res_sym        = rule_rdata.sym;
                cur_state_next = rule_rdata.state;
                case (rule_rdata.move)
                    MOVE_LEFT:
                    begin
                        // The head stops at cell 0.
                        if (head_reg != '0)
                        begin
                            head_next = head_reg - 1'b1;
                        end
                    end
                    MOVE_RIGHT:
                    begin
                        head_next = head_reg + 1'b1;
                    end
                    default:
                    begin
                        head_next = head_reg;
                    end
                endcase
            end
        end
        else if (req_mode_reg == MODE_STEP)
        begin
            // A step that reaches the finish state directly had the head off the tape.
            res_status = STAT_BEYOND;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tape_len_reg  <= LEN_W'(1024);
            cur_state_reg <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tape_len_reg <= cfg_data;
            end
            if (apply_write)
            begin
                cur_state_reg <= cur_state_next;
                head_reg      <= head_next;
            end
            if (seq_out.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (seq_out.accept)
        begin
            req_mode_reg   <= in_mode;
            req_rsym_reg   <= read_symbol;
            req_fst_reg    <= from_state;
            req_wsym_reg   <= write_symbol;
            req_tst_reg    <= to_state;
            req_move_reg   <= head_move;
            req_add_ok_reg <= fst_ok && tst_ok;
        end
        if (seq_out.fire)
        begin
            out_status_reg <= res_status;
            out_state_reg  <= cur_state_next;
            out_head_reg   <= head_next;
            out_sym_reg    <= res_sym;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign machine_state  = out_state_reg;
    assign head_position  = out_head_reg;
    assign written_symbol = out_sym_reg;

endmodule

@@ rtl/tmse_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing; depth and width come from parameters.
module tmse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is requested.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tmse_ctrl.sv @@
// Sequencer of the step engine: rule table clearing pass and per-request states.
// Depends on tmse_pkg for the state enum and the control structs.
module tmse_ctrl
    import tmse_pkg::*;
#(
    parameter int RULE_AW = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  seq_in_t            seq_in,
    output seq_out_t           seq_out,
    output logic [RULE_AW-1:0] clr_addr
);

    fsm_t               state_reg, state_next;
    logic [RULE_AW-1:0] clr_cnt_reg, clr_cnt_next;

    // State and clear counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= FSM_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Next state and controls.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        seq_out      = '0;
        case (state_reg)
            FSM_CLEAR:
            begin
                // Walk every rule entry once, writing it invalid.
                seq_out.clearing = 1'b1;
                clr_cnt_next     = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE:
            begin
                seq_out.in_ready = 1'b1;
                if (seq_in.in_valid)
                begin
                    seq_out.accept = 1'b1;
                    if (seq_in.mode == MODE_ADD)
                    begin
                        state_next = FSM_ADD_CHK;
                    end
                    else if (seq_in.mode == MODE_STEP && seq_in.head_ok)
                    begin
                        state_next = FSM_STEP_RULE;
                    end
                    else
                    begin
                        state_next = FSM_FINISH;
                    end
                end
            end
            FSM_STEP_RULE:
            begin
                // Tape cell is back; look up the rule for it.
                seq_out.lookup = 1'b1;
                state_next     = FSM_STEP_APPLY;
            end
            FSM_ADD_CHK, FSM_STEP_APPLY, FSM_FINISH:
            begin
                // Finish once the output register can take the result.
                seq_out.at_add   = (state_reg == FSM_ADD_CHK);
                seq_out.at_apply = (state_reg == FSM_STEP_APPLY);
                if (seq_in.out_free)
                begin
                    seq_out.fire = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    assign clr_addr = clr_cnt_reg;

endmodule

@@ rtl/tmse_checker.sv @@
// Port-level checks for the step engine, bound to the top level.
// Depends on tmse_pkg for the status codes.
module tmse_checker
    import tmse_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [STAT_W-1:0] status,
    input logic [SYM_W-1:0]  written_symbol
);

    // A stalled result holds its status.
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("result changed while stalled");

    // Requests are taken one at a time: no request right after an accepted one.
    property p_one_at_a_time;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty
    a_one_at_a_time: assert property (p_one_at_a_time)
        else $error("request accepted in back-to-back cycles");

    // The unused status code never shows.
    property p_status_code;
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3;
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("undefined status code");

    // Only a successful request reports a written symbol.
    property p_sym_on_fail;
        @(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> written_symbol == '0;
    endproperty
    a_sym_on_fail: assert property (p_sym_on_fail)
        else $error("written symbol reported on a failed step");

endmodule

bind turing_machine_step_engine_core tmse_checker u_tmse_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .written_symbol (written_symbol)
);
